[design/csao_pkg.sv]
package csao_pkg;

  localparam int unsigned SPRITE_WIDTH_DEF  = 16;
  localparam int unsigned SPRITE_HEIGHT_DEF = 24;

  localparam int unsigned POS_W    = 12;
  localparam int unsigned SLOT_W   = 9;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SCREEN_W = 13;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_MOVE  = 2'd1;
  localparam logic [1:0] OP_BLEND = 2'd2;

  localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [SLOT_W-1:0] sprite_slot;
    logic [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] pixel;
    logic              covered;
  } out_item_t;

endpackage

[design/csao_ram.sv]
module csao_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 384,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/cursor_sprite_alpha_overlay.sv]
// A blend request is registered in stages 1, 2 and 3 before out_valid_o shows its result.
// Throughput: one request per cycle when not stalled; separate RAM write and read ports.
// Load and move requests take effect on acceptance and produce no result.
// Reset clears the pipeline valids, hides the cursor at 0,0 and sets the screen to 1024x768.
// Sprite memory contents are not cleared by reset.
module cursor_sprite_alpha_overlay #(
  parameter int unsigned SPRITE_WIDTH  = csao_pkg::SPRITE_WIDTH_DEF,
  parameter int unsigned SPRITE_HEIGHT = csao_pkg::SPRITE_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  csao_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output csao_pkg::out_item_t               out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [csao_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [csao_pkg::SCREEN_W-1:0]     cfg_data_i
);

  localparam int unsigned DEPTH  = SPRITE_WIDTH * SPRITE_HEIGHT;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LIN_W  = 2 * csao_pkg::POS_W;
  localparam int unsigned NUM_W  = 2 * csao_pkg::CHAN_W;

  // Exact floor(n / 255) for n below 65280.
  function automatic logic [csao_pkg::CHAN_W-1:0] div255(input logic [NUM_W-1:0] n);
    logic [NUM_W:0] t;
    t = (NUM_W+1)'(n) + (NUM_W+1)'(n >> csao_pkg::CHAN_W) + (NUM_W+1)'(1);
    return t[NUM_W-1:csao_pkg::CHAN_W];
  endfunction

  function automatic logic [NUM_W-1:0] mix(input logic [csao_pkg::CHAN_W-1:0] s,
                                           input logic [csao_pkg::CHAN_W-1:0] d,
                                           input logic [csao_pkg::CHAN_W-1:0] a);
    logic [csao_pkg::CHAN_W-1:0] ia;
    ia = csao_pkg::ALPHA_OPAQUE - a;
    return NUM_W'(s) * NUM_W'(a) + NUM_W'(d) * NUM_W'(ia);
  endfunction

  // Configuration and cursor state.
  logic [csao_pkg::SCREEN_W-1:0] scr_w_q, scr_h_q;
  logic [csao_pkg::POS_W-1:0]    left_q, left_d, top_q, top_d;
  logic                          shown_q, shown_d;

  // Pipeline stage enables, from the output back to the input.
  logic en1, en2, en3, accept;

  assign en3        = !out_valid_o || !out_stall_i;
  logic v1_q, v2_q, ov_q;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;
  assign accept     = in_valid_i && en1;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= csao_pkg::SCREEN_WIDTH_RST;
      scr_h_q <= csao_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        csao_pkg::CFG_SCREEN_WIDTH:  scr_w_q <= cfg_data_i;
        csao_pkg::CFG_SCREEN_HEIGHT: scr_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    left_d  = left_q;
    top_d   = top_q;
    shown_d = shown_q;
    if (accept && in_item_i.opcode == csao_pkg::OP_MOVE) begin
      left_d  = in_item_i.pos_x;
      top_d   = in_item_i.pos_y;
      shown_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      top_q   <= '0;
      shown_q <= 1'b0;
    end else begin
      left_q  <= left_d;
      top_q   <= top_d;
      shown_q <= shown_d;
    end
  end

  // Window test and sprite address for the incoming pixel.
  logic [csao_pkg::POS_W-1:0] dx, dy;
  logic [LIN_W-1:0]           lin;
  logic                       hit;
  logic [ADDR_W-1:0]          raddr, waddr;
  logic [csao_pkg::SCREEN_W-1:0] slot_ext;
  logic                       we;

  always_comb begin
    dx  = in_item_i.pos_x - left_q;
    dy  = in_item_i.pos_y - top_q;
    hit = shown_q
          && in_item_i.pos_x >= left_q && in_item_i.pos_y >= top_q
          && csao_pkg::SCREEN_W'(in_item_i.pos_x) < scr_w_q
          && csao_pkg::SCREEN_W'(in_item_i.pos_y) < scr_h_q
          && LIN_W'(dx) < LIN_W'(SPRITE_WIDTH)
          && LIN_W'(dy) < LIN_W'(SPRITE_HEIGHT);
    lin   = LIN_W'(dy) * LIN_W'(SPRITE_WIDTH) + LIN_W'(dx);
    raddr = lin[ADDR_W-1:0];
    slot_ext = csao_pkg::SCREEN_W'(in_item_i.sprite_slot);
    waddr = slot_ext[ADDR_W-1:0];
    we    = accept && in_item_i.opcode == csao_pkg::OP_LOAD
            && LIN_W'(in_item_i.sprite_slot) < LIN_W'(DEPTH);
  end

  logic [csao_pkg::WORD_W-1:0] spr;

  csao_ram #(
    .WIDTH (csao_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_sprite_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_item_i.value),
    .re_i    (en1),
    .raddr_i (raddr),
    .rdata_o (spr)
  );

  // Stage 1: sprite word arrives from memory.
  logic                        hit1_q;
  logic [csao_pkg::WORD_W-1:0] bg1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= accept && in_item_i.opcode == csao_pkg::OP_BLEND;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      hit1_q <= hit;
      bg1_q  <= in_item_i.value;
    end
  end

  // Stage 2: per-channel weighted sums.
  logic [csao_pkg::CHAN_W-1:0] a1;
  logic                        cov2_q, opq2_q;
  logic [csao_pkg::WORD_W-1:0] spr2_q, bg2_q;
  logic [NUM_W-1:0]            nr_q, ng_q, nb_q;

  assign a1 = spr[31:24];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      cov2_q <= hit1_q && a1 != csao_pkg::ALPHA_CLEAR;
      opq2_q <= a1 == csao_pkg::ALPHA_OPAQUE;
      spr2_q <= spr;
      bg2_q  <= bg1_q;
      nr_q   <= mix(spr[23:16], bg1_q[23:16], a1);
      ng_q   <= mix(spr[15:8],  bg1_q[15:8],  a1);
      nb_q   <= mix(spr[7:0],   bg1_q[7:0],   a1);
    end
  end

  // Stage 3: divide, select and hold the result.
  csao_pkg::out_item_t out_d, out_q;

  always_comb begin
    out_d.covered = cov2_q;
    if (!cov2_q) begin
      out_d.pixel = bg2_q;
    end else if (opq2_q) begin
      out_d.pixel = spr2_q;
    end else begin
      out_d.pixel = {csao_pkg::ALPHA_OPAQUE, div255(nr_q), div255(ng_q), div255(nb_q)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en3) begin
      ov_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;

endmodule

[tb/tb_cursor_sprite_alpha_overlay.sv]
`timescale 1ns / 1ps

module tb_cursor_sprite_alpha_overlay;
  import csao_pkg::*;

  localparam int unsigned SPR_W     = SPRITE_WIDTH_DEF;
  localparam int unsigned SPR_H     = SPRITE_HEIGHT_DEF;
  localparam int unsigned SPR_WORDS = SPR_W * SPR_H;
  localparam int unsigned PIPE_LAT  = 3;
  localparam int unsigned RAND_ITEMS = 1100;
  localparam int unsigned RAND_PHASES = 6;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic      req_valid = 1'b0;
  in_item_t  req_item  = '0;
  logic      req_stall;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_item_t res_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SCREEN_W-1:0]  cfg_data  = '0;

  cursor_sprite_alpha_overlay dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_item_i   (req_item),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_item_o  (res_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the overlay state.
  logic [WORD_W-1:0]   sprite_mem [SPR_WORDS];
  logic [POS_W-1:0]    cur_left  = '0;
  logic [POS_W-1:0]    cur_top   = '0;
  logic                cur_shown = 1'b0;
  logic [SCREEN_W-1:0] scr_w     = SCREEN_WIDTH_RST;
  logic [SCREEN_W-1:0] scr_h     = SCREEN_HEIGHT_RST;

  in_item_t  request_q[$];
  out_item_t pixel_expect_q[$];
  int unsigned fail_count = 0;

  // Cursor position as seen by the request generator.
  logic [POS_W-1:0] gen_left = '0;
  logic [POS_W-1:0] gen_top  = '0;

  function automatic logic [CHAN_W-1:0] mix_chan(input logic [CHAN_W-1:0] s,
                                                 input logic [CHAN_W-1:0] d,
                                                 input logic [CHAN_W-1:0] a);
    int unsigned num;
    num = int'(s) * int'(a) + int'(d) * (255 - int'(a));
    return CHAN_W'(num / 255);
  endfunction

  task automatic overlay_step(input in_item_t it);
    out_item_t         res;
    logic [WORD_W-1:0] s;
    logic [POS_W-1:0]  dx;
    logic [POS_W-1:0]  dy;
    case (it.opcode)
      OP_LOAD: begin
        if (it.sprite_slot < SPR_WORDS) sprite_mem[it.sprite_slot] = it.value;
      end
      OP_MOVE: begin
        cur_left  = it.pos_x;
        cur_top   = it.pos_y;
        cur_shown = 1'b1;
      end
      OP_BLEND: begin
        res.pixel   = it.value;
        res.covered = 1'b0;
        if (cur_shown && it.pos_x >= cur_left && it.pos_y >= cur_top &&
            it.pos_x < scr_w && it.pos_y < scr_h) begin
          dx = it.pos_x - cur_left;
          dy = it.pos_y - cur_top;
          if (dx < SPR_W && dy < SPR_H) begin
            s = sprite_mem[dy * SPR_W + dx];
            if (s[31:24] == ALPHA_OPAQUE) begin
              res.pixel   = s;
              res.covered = 1'b1;
            end else if (s[31:24] != ALPHA_CLEAR) begin
              res.pixel = {ALPHA_OPAQUE,
                           mix_chan(s[23:16], it.value[23:16], s[31:24]),
                           mix_chan(s[15:8], it.value[15:8], s[31:24]),
                           mix_chan(s[7:0], it.value[7:0], s[31:24])};
              res.covered = 1'b1;
            end
          end
        end
        pixel_expect_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(12, 48);
  endfunction

  // Request driver.
  int unsigned send_gap  = 0;
  int unsigned send_calm = 0;
  logic        hold_for_drain = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_item  <= '0;
    end else begin
      if (req_valid && !req_stall) overlay_step(req_item);
      if (!req_valid || !req_stall) begin
        if (hold_for_drain && pixel_expect_q.size() != 0) begin
          req_valid <= 1'b0;
        end else if (send_gap != 0) begin
          hold_for_drain = 1'b0;
          send_gap--;
          req_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          hold_for_drain = 1'b0;
          req_item  <= request_q.pop_front();
          req_valid <= 1'b1;
          if (send_calm != 0) begin
            send_calm--;
          end else begin
            send_gap = pick_idle();
            if ($urandom_range(0, 99) == 0) send_calm = $urandom_range(30, 80);
          end
          // Now and then the sender waits until every result is back.
          if ($urandom_range(0, 149) == 0) hold_for_drain = 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  int unsigned stall_left = 0;
  int unsigned stall_calm = 0;
  out_item_t   want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (pixel_expect_q.size() == 0) begin
          $error("result with no request waiting: pixel %08h covered %0b",
                 res_item.pixel, res_item.covered);
          fail_count++;
        end else begin
          want = pixel_expect_q.pop_front();
          if (res_item.pixel !== want.pixel) begin
            $error("pixel mismatch: expected %08h, got %08h", want.pixel, res_item.pixel);
            fail_count++;
          end
          if (res_item.covered !== want.covered) begin
            $error("covered mismatch: expected %0b, got %0b", want.covered,
                   res_item.covered);
            fail_count++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
        if (stall_calm != 0) begin
          stall_calm--;
        end else begin
          stall_left = pick_idle();
          if ($urandom_range(0, 99) == 0) stall_calm = $urandom_range(30, 80);
        end
      end
    end
  end

  task automatic push_req(input logic [1:0] op, input logic [POS_W-1:0] x,
                          input logic [POS_W-1:0] y, input logic [SLOT_W-1:0] slot,
                          input logic [WORD_W-1:0] val);
    in_item_t it;
    it.opcode      = op;
    it.pos_x       = x;
    it.pos_y       = y;
    it.sprite_slot = slot;
    it.value       = val;
    request_q.push_back(it);
    if (op == OP_MOVE) begin
      gen_left = x;
      gen_top  = y;
    end
  endtask

  function automatic logic [WORD_W-1:0] rand_sprite_word();
    logic [WORD_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 5))
      0: w[31:24] = ALPHA_CLEAR;
      1: w[31:24] = ALPHA_OPAQUE;
      2: w[31:24] = ($urandom_range(0, 1) != 0) ? 8'h01 : 8'hFE;
      default: ;
    endcase
    return w;
  endfunction

  // Mostly near the screen edge or the origin, so that clipping is exercised.
  function automatic logic [POS_W-1:0] pick_coord(input logic [SCREEN_W-1:0] lim);
    int unsigned top;
    int unsigned off;
    top = (lim > 4096) ? 4096 : lim;
    off = $urandom_range(1, 20);
    case ($urandom_range(0, 2))
      0: return POS_W'($urandom);
      1: return (top > off) ? POS_W'(top - off) : '0;
      default: return POS_W'($urandom_range(0, 24));
    endcase
  endfunction

  // The driver may pop a request in the same time step as the first check, so the
  // idle condition is confirmed again after the pipeline margin.
  task automatic wait_idle();
    do begin
      while (request_q.size() != 0 || req_valid || pixel_expect_q.size() != 0)
        @(posedge clk_i);
      repeat (PIPE_LAT + 4) @(posedge clk_i);
    end while (request_q.size() != 0 || req_valid || pixel_expect_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCREEN_W-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SCREEN_WIDTH) scr_w = data;
    else if (idx == CFG_SCREEN_HEIGHT) scr_h = data;
  endtask

  task automatic set_screen(input logic [SCREEN_W-1:0] w, input logic [SCREEN_W-1:0] h);
    wait_idle();
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
  endtask

  initial begin
    logic [SCREEN_W-1:0] ph_w [RAND_PHASES];
    logic [SCREEN_W-1:0] ph_h [RAND_PHASES];
    int unsigned counted;
    int unsigned r;
    logic [SLOT_W-1:0] slot;

    ph_w = '{13'd1024, 13'd4096, 13'd8191, 13'd20, 13'd0, 13'd0};
    ph_h = '{13'd768, 13'd4096, 13'd8191, 13'd30, 13'd0, 13'd0};
    ph_w[4] = SCREEN_W'($urandom_range(1, 4096));
    ph_h[4] = SCREEN_W'($urandom_range(1, 4096));
    ph_w[5] = SCREEN_W'($urandom_range(1, 64));
    ph_h[5] = SCREEN_W'($urandom_range(1, 4096));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The cursor is still hidden, so blends pass through untouched.
    push_req(OP_BLEND, '0, '0, '0, '0);
    push_req(OP_BLEND, '1, '1, '1, '1);
    push_req(OP_UNUSED, '1, '1, '1, '1);
    push_req(OP_LOAD, '0, '0, SLOT_W'(SPR_WORDS), 32'hFF00_FF00);
    push_req(OP_LOAD, '1, '1, '1, '1);

    // Fill the whole sprite before any covered read can happen.
    for (int i = 0; i < SPR_WORDS; i++)
      push_req(OP_LOAD, POS_W'($urandom), POS_W'($urandom), SLOT_W'(i), rand_sprite_word());
    push_req(OP_LOAD, '0, '0, 9'd0, 32'h0012_3456);
    push_req(OP_LOAD, '0, '0, 9'd1, 32'hFFAB_CDEF);
    push_req(OP_LOAD, '0, '0, 9'd2, 32'h80FF_00FF);
    push_req(OP_LOAD, '0, '0, 9'd3, 32'h01FF_FFFF);
    push_req(OP_LOAD, '0, '0, 9'd4, 32'hFE00_0000);
    push_req(OP_LOAD, '0, '0, SLOT_W'(SPR_WORDS - 1), 32'h7F10_2030);

    push_req(OP_MOVE, '0, '0, '1, '1);
    for (int i = 0; i < 5; i++)
      push_req(OP_BLEND, POS_W'(i), '0, '0, (i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0);
    push_req(OP_BLEND, POS_W'(SPR_W - 1), POS_W'(SPR_H - 1), '0, 32'h00C0_FFEE);
    push_req(OP_BLEND, POS_W'(SPR_W), '0, '0, 32'h1234_5678);
    push_req(OP_BLEND, '0, POS_W'(SPR_H), '0, 32'h1234_5678);
    push_req(OP_MOVE, 12'd1016, 12'd760, '0, '0);
    push_req(OP_BLEND, 12'd1023, 12'd767, '0, 32'hA5A5_A5A5);
    push_req(OP_BLEND, 12'd1024, 12'd767, '0, 32'hA5A5_A5A5);
    push_req(OP_BLEND, 12'd1015, 12'd767, '0, 32'hA5A5_A5A5);
    push_req(OP_MOVE, 12'd4094, 12'd4095, '0, '0);
    push_req(OP_BLEND, 12'd4095, 12'd4095, '0, 32'h5A5A_5A5A);

    set_screen(13'd4096, 13'd4096);
    push_req(OP_BLEND, 12'd4095, 12'd4095, '0, 32'h5A5A_5A5A);
    // A zero screen size leaves every pixel uncovered.
    set_screen(13'd0, 13'd4096);
    push_req(OP_BLEND, 12'd4095, 12'd4095, '0, 32'h5A5A_5A5A);
    set_screen(13'd4096, 13'd0);
    push_req(OP_BLEND, 12'd4095, 12'd4095, '0, 32'h5A5A_5A5A);
    wait_idle();
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, '1);
    set_screen(13'd8191, 13'd1);
    push_req(OP_MOVE, '0, '0, '0, '0);
    push_req(OP_BLEND, 12'd1, 12'd0, '0, 32'h0F0F_0F0F);
    push_req(OP_BLEND, 12'd1, 12'd1, '0, 32'h0F0F_0F0F);
    set_screen(13'd1, 13'd8191);
    push_req(OP_BLEND, 12'd1, 12'd0, '0, 32'h0F0F_0F0F);
    push_req(OP_BLEND, 12'd0, 12'd1, '0, 32'h0F0F_0F0F);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_screen(ph_w[ph], ph_h[ph]);
      if (ph == 3) write_reg(CFG_SPARE_A, 13'h0AAA);
      push_req(OP_MOVE, pick_coord(scr_w), pick_coord(scr_h), SLOT_W'($urandom), $urandom);
      counted = 0;
      while (counted < RAND_ITEMS / RAND_PHASES) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          push_req(OP_MOVE, pick_coord(scr_w), pick_coord(scr_h), SLOT_W'($urandom), $urandom);
          counted++;
        end else if (r < 22) begin
          slot = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom)
                                             : SLOT_W'($urandom_range(0, SPR_WORDS - 1));
          push_req(OP_LOAD, POS_W'($urandom), POS_W'($urandom), slot, rand_sprite_word());
          if (slot < SPR_WORDS) counted++;
        end else if (r < 24) begin
          push_req(OP_UNUSED, POS_W'($urandom), POS_W'($urandom), SLOT_W'($urandom), $urandom);
        end else if (r < 81) begin
          push_req(OP_BLEND, POS_W'(gen_left + $urandom_range(0, SPR_W + 2)),
                   POS_W'(gen_top + $urandom_range(0, SPR_H + 2)), SLOT_W'($urandom), $urandom);
          counted++;
        end else begin
          push_req(OP_BLEND, pick_coord(scr_w), pick_coord(scr_h), SLOT_W'($urandom), $urandom);
          counted++;
        end
      end
    end

    wait_idle();
    if (fail_count == 0 && pixel_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(64'd20_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
